@@ design/sem_pkg.sv @@
`default_nettype none
package sem_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 11;
  localparam int PIX_W      = 24;
  localparam int ENERGY_W   = 21;

  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

  localparam logic [1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_THREE_CHANNELS = 2'd2;

  typedef struct packed {
    logic [7:0] pixel_ch0;
    logic [7:0] pixel_ch1;
    logic [7:0] pixel_ch2;
  } in_t;

  typedef struct packed {
    logic [7:0]       magnitude_ch0;
    logic [7:0]       magnitude_ch1;
    logic [7:0]       magnitude_ch2;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             last_of_run;
  } out_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       index;
    logic [DIM_W-1:0] data;
  } cfg_req_t;

  // [row: upper, middle, current][col: oldest .. newest]
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic             interior;
    logic             three;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    win_t             taps;
  } job_t;

endpackage
`default_nettype wire

@@ design/sobel_edge_magnitude_core.sv @@
// Streaming 3x3 Sobel gradient magnitude, one raster pixel per request with
// up to three 8-bit channels; each result is floor(sqrt(gx^2+gy^2)) per
// channel, saturated to 255, lagging the input by one row and one column,
// with zero magnitudes on the border and no result for the last image row.
// A pixel passes the front as accept, line-buffer read-modify-write and job
// hand-off (one per result, stalled while the job queue is full); no new
// pixel is taken until it is done. Each result then passes the back as queue
// pop, gradient and squares, an 8-step square-root iteration and output load;
// the back works on one job at a time. A row-end pixel can cause two results.
// Writing image_width or image_height restarts the frame; write configuration
// only with no pixel in flight and the result side drained.
`default_nettype none
module sobel_edge_magnitude_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  output      logic          full,
  input  wire sem_pkg::in_t  in_pixel,
  output      logic          empty,
  input  wire logic          pop,
  output      sem_pkg::out_t out_result,
  input  wire logic          valid,
  output      logic          ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [10:0]   cfg_data
);
  import sem_pkg::*;

  cfg_req_t cfg;
  logic     q_push, q_full, q_pop, q_empty;
  job_t     q_wdata, q_rdata;

  assign ready     = 1'b1;
  assign cfg.valid = valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  sem_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_pixel(in_pixel),
    .cfg     (cfg),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  sem_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .empty    (q_empty)
  );

  sem_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .empty     (empty),
    .pop       (pop),
    .out_result(out_result)
  );

endmodule
`default_nettype wire

@@ design/sem_ram.sv @@
`default_nettype none
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/sem_front.sv @@
`default_nettype none
module sem_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output      logic             full,
  input  wire sem_pkg::in_t     in_pixel,
  input  wire sem_pkg::cfg_req_t cfg,
  output      logic             q_push,
  output      sem_pkg::job_t    q_data,
  input  wire logic             q_full
);
  import sem_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE   = 3'b001,
    F_UPDATE = 3'b010,
    F_EMIT   = 3'b100
  } fstate_t;

  fstate_t          state_r, state_nxt;
  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic             three_r, three_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_lat_r, col_lat_nxt;
  logic [ROW_W-1:0] row_lat_r, row_lat_nxt;
  logic [PIX_W-1:0] cur_r, cur_nxt;
  win_t             tap_r, tap_nxt;
  logic             pend_a_r, pend_a_nxt;
  logic             pend_b_r, pend_b_nxt;

  logic [DIM_W-1:0] w_eff, h_eff;
  logic             accept;
  logic             row_end, lat_row_end;
  logic [2*PIX_W-1:0] lb_rdata, lb_wdata;
  logic [PIX_W-1:0] lb_up, lb_mid;
  logic             lb_we;

  assign w_eff = (width_r == '0) ? DIM_W'(1) :
                 (width_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_r;
  assign h_eff = (height_r == '0) ? DIM_W'(1) :
                 (height_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_r;

  assign full   = (state_r != F_IDLE);
  assign accept = push && !full;

  assign row_end     = ({1'b0, col_r} + DIM_W'(1)) >= w_eff;
  assign lat_row_end = ({1'b0, col_lat_r} + DIM_W'(1)) >= w_eff;

  // entry holds {middle, upper}
  assign lb_up    = lb_rdata[PIX_W-1:0];
  assign lb_mid   = lb_rdata[2*PIX_W-1:PIX_W];
  assign lb_wdata = {cur_r, lb_mid};
  assign lb_we    = (state_r == F_UPDATE);

  sem_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_buf (
    .clk  (clk),
    .we   (lb_we),
    .waddr(col_lat_r),
    .wdata(lb_wdata),
    .re   (accept),
    .raddr(col_r),
    .rdata(lb_rdata)
  );

  always_comb begin
    q_push          = (state_r == F_EMIT) && (pend_a_r || pend_b_r) && !q_full;
    q_data.three    = three_r;
    q_data.row      = row_lat_r - ROW_W'(1);
    q_data.taps     = tap_r;
    if (pend_a_r) begin
      q_data.interior = (row_lat_r >= ROW_W'(2)) && (col_lat_r >= COL_W'(2));
      q_data.last     = !pend_b_r;
      q_data.col      = col_lat_r - COL_W'(1);
    end else begin
      q_data.interior = 1'b0;
      q_data.last     = 1'b1;
      q_data.col      = COL_W'(w_eff - DIM_W'(1));
    end
  end

  always_comb begin
    state_nxt   = state_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    three_nxt   = three_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    col_lat_nxt = col_lat_r;
    row_lat_nxt = row_lat_r;
    cur_nxt     = cur_r;
    tap_nxt     = tap_r;
    pend_a_nxt  = pend_a_r;
    pend_b_nxt  = pend_b_r;

    if (cfg.valid) begin
      case (cfg.index)
        CFG_IMAGE_WIDTH: begin
          width_nxt = cfg.data;
          col_nxt   = '0;
          row_nxt   = '0;
        end
        CFG_IMAGE_HEIGHT: begin
          height_nxt = cfg.data;
          col_nxt    = '0;
          row_nxt    = '0;
        end
        CFG_THREE_CHANNELS: begin
          three_nxt = cfg.data[0];
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = (({1'b0, row_r} + DIM_W'(1)) >= h_eff) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end

    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          col_lat_nxt = col_r;
          row_lat_nxt = row_r;
          cur_nxt     = {in_pixel.pixel_ch2, in_pixel.pixel_ch1, in_pixel.pixel_ch0};
          state_nxt   = F_UPDATE;
        end
      end
      F_UPDATE: begin
        for (int i = 0; i < 3; i++) begin
          tap_nxt[i][0] = tap_r[i][1];
          tap_nxt[i][1] = tap_r[i][2];
        end
        tap_nxt[0][2] = lb_up;
        tap_nxt[1][2] = lb_mid;
        tap_nxt[2][2] = cur_r;
        pend_a_nxt    = (row_lat_r != '0) && (col_lat_r != '0);
        pend_b_nxt    = (row_lat_r != '0) && lat_row_end;
        state_nxt     = F_EMIT;
      end
      F_EMIT: begin
        if (!pend_a_r && !pend_b_r) begin
          state_nxt = F_IDLE;
        end else if (!q_full) begin
          if (pend_a_r) begin
            pend_a_nxt = 1'b0;
            if (!pend_b_r) state_nxt = F_IDLE;
          end else begin
            pend_b_nxt = 1'b0;
            state_nxt  = F_IDLE;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      width_r  <= DIM_W'(640);
      height_r <= DIM_W'(480);
      three_r  <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
      tap_r    <= '0;
      pend_a_r <= 1'b0;
      pend_b_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      three_r  <= three_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      tap_r    <= tap_nxt;
      pend_a_r <= pend_a_nxt;
      pend_b_r <= pend_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_lat_r <= col_lat_nxt;
    row_lat_r <= row_lat_nxt;
    cur_r     <= cur_nxt;
  end

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == F_UPDATE)
    else $error("front did not move to update after accepting a pixel");

  a_push_pending: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (state_r == F_EMIT) && (pend_a_r || pend_b_r))
    else $error("job pushed with nothing pending");

  a_last_border: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !pend_a_r |-> q_data.last && !q_data.interior)
    else $error("row-end job must be a final border job");

endmodule
`default_nettype wire

@@ design/sem_jobq.sv @@
`default_nettype none
module sem_jobq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sem_pkg::job_t push_data,
  output      logic          full,
  input  wire logic          pop,
  output      sem_pkg::job_t pop_data,
  output      logic          empty
);
  import sem_pkg::*;

  job_t                  mem_r [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [JOBQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [JOBQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign full     = (cnt_r == JOBQ_CNT_W'(JOBQ_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_r + JOBQ_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_r + JOBQ_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + JOBQ_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - JOBQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

@@ design/sem_back.sv @@
`default_nettype none
module sem_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  output      logic          q_pop,
  input  wire sem_pkg::job_t q_data,
  output      logic          empty,
  input  wire logic          pop,
  output      sem_pkg::out_t out_result
);
  import sem_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_GRAD = 4'b0010,
    B_ROOT = 4'b0100,
    B_OUT  = 4'b1000
  } bstate_t;

  bstate_t                   state_r, state_nxt;
  job_t                      job_r;
  logic [2:0][ENERGY_W-1:0]  sq_r, sq_nxt;
  logic [2:0][7:0]           res_r, res_nxt;
  logic [2:0]                bit_r, bit_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_t                      out_r, out_nxt;
  logic [2:0][7:0]           mag;

  function automatic logic [7:0] px(input win_t w, input int i, input int j, input int c);
    return w[i][j][8*c +: 8];
  endfunction

  function automatic logic [ENERGY_W-1:0] grad_energy(input win_t w, input int c);
    logic [9:0]         s_r, s_l, s_b, s_t;
    logic signed [10:0] gx, gy;
    logic signed [21:0] gx2, gy2;
    s_r = {2'b0, px(w, 0, 2, c)} + {1'b0, px(w, 1, 2, c), 1'b0} + {2'b0, px(w, 2, 2, c)};
    s_l = {2'b0, px(w, 0, 0, c)} + {1'b0, px(w, 1, 0, c), 1'b0} + {2'b0, px(w, 2, 0, c)};
    s_b = {2'b0, px(w, 2, 0, c)} + {1'b0, px(w, 2, 1, c), 1'b0} + {2'b0, px(w, 2, 2, c)};
    s_t = {2'b0, px(w, 0, 0, c)} + {1'b0, px(w, 0, 1, c), 1'b0} + {2'b0, px(w, 0, 2, c)};
    gx  = $signed({1'b0, s_r}) - $signed({1'b0, s_l});
    gy  = $signed({1'b0, s_b}) - $signed({1'b0, s_t});
    gx2 = gx * gx;
    gy2 = gy * gy;
    return {1'b0, gx2[19:0]} + {1'b0, gy2[19:0]};
  endfunction

  assign q_pop      = (state_r == B_IDLE) && !q_empty;
  assign empty      = !out_valid_r;
  assign out_result = out_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag[c] = (sq_r[c][ENERGY_W-1:16] != '0) ? 8'hFF : res_r[c];
    end
  end

  always_comb begin
    logic [7:0]  t;
    logic [15:0] tt;
    state_nxt     = state_r;
    sq_nxt        = sq_r;
    res_nxt       = res_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    t             = '0;
    tt            = '0;

    if (out_valid_r && pop) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) state_nxt = B_GRAD;
      end
      B_GRAD: begin
        for (int c = 0; c < 3; c++) begin
          sq_nxt[c] = grad_energy(job_r.taps, c);
        end
        res_nxt   = '0;
        bit_nxt   = 3'd7;
        state_nxt = B_ROOT;
      end
      B_ROOT: begin
        for (int c = 0; c < 3; c++) begin
          t  = res_r[c] | (8'd1 << bit_r);
          tt = t * t;
          if ({{(ENERGY_W-16){1'b0}}, tt} <= sq_r[c]) res_nxt[c] = t;
        end
        bit_nxt = bit_r - 3'd1;
        if (bit_r == '0) state_nxt = B_OUT;
      end
      B_OUT: begin
        if (!out_valid_r || pop) begin
          out_nxt.magnitude_ch0 = job_r.interior ? mag[0] : 8'd0;
          out_nxt.magnitude_ch1 = (job_r.interior && job_r.three) ? mag[1] : 8'd0;
          out_nxt.magnitude_ch2 = (job_r.interior && job_r.three) ? mag[2] : 8'd0;
          out_nxt.out_row       = job_r.row;
          out_nxt.out_col       = job_r.col;
          out_nxt.last_of_run   = job_r.last;
          out_valid_nxt         = 1'b1;
          state_nxt             = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_data;
    sq_r  <= sq_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    out_r <= out_nxt;
  end

  a_grad_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_GRAD |-> $past(q_pop))
    else $error("gradient stage entered without a job");

  a_root_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_ROOT && bit_r == '0 |=> state_r == B_OUT)
    else $error("root iteration did not end after its last bit");

endmodule
`default_nettype wire
